FILE: src/lefe_pkg.sv
// ============================================================================
// lefe_pkg: shared types and constants of the LED effect frame engine
// Holds channel payloads, job records, register and code definitions.
// ============================================================================
package lefe_pkg;

    localparam int LED_BYTES_MAX = 48;
    localparam int RAW_BYTES_MAX = 1024;
    localparam int FADE_STEPS    = 64;

    localparam int RAW_AW  = $clog2(RAW_BYTES_MAX);
    localparam int FADE_W  = $clog2(FADE_STEPS);
    localparam int LEN_W   = 11;
    localparam int CNT_W   = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Opcodes of the input channel
    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_TICK       = 3'd1;
    localparam logic [2:0] OP_UPDATE_ON  = 3'd2;
    localparam logic [2:0] OP_UPDATE_OFF = 3'd3;
    localparam logic [2:0] OP_LOAD_INIT  = 3'd4;
    localparam logic [2:0] OP_LOAD_UPD   = 3'd5;

    // Light modes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_INIT_PAT = 3'd1;
    localparam logic [2:0] MODE_INIT_RAW = 3'd2;
    localparam logic [2:0] MODE_UPD_PAT  = 3'd3;
    localparam logic [2:0] MODE_UPD_RAW  = 3'd4;

    // init_mode register codes
    localparam logic [1:0] INIT_SEL_PAT = 2'd1;
    localparam logic [1:0] INIT_SEL_RAW = 2'd2;

    // Job kinds carried from the front to the back
    localparam logic [2:0] JOB_PAT       = 3'd0;
    localparam logic [2:0] JOB_INIT_RAW  = 3'd1;
    localparam logic [2:0] JOB_UPD_RAW   = 3'd2;
    localparam logic [2:0] JOB_LOAD_INIT = 3'd3;
    localparam logic [2:0] JOB_LOAD_UPD  = 3'd4;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_LED_COUNT   = 3'd0;
    localparam logic [2:0] REG_INIT_MODE   = 3'd1;
    localparam logic [2:0] REG_UPD_ENABLE  = 3'd2;
    localparam logic [2:0] REG_UPD_PATTERN = 3'd3;
    localparam logic [2:0] REG_INIT_LEN    = 3'd4;
    localparam logic [2:0] REG_UPD_LEN     = 3'd5;

    localparam logic [23:0] COLOUR_0 = 24'hFF0000;
    localparam logic [23:0] COLOUR_1 = 24'hCC00FF;
    localparam logic [23:0] COLOUR_2 = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  store_address;
        logic [7:0]  store_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [5:0]  byte_index;
        logic        last_byte;
        logic [2:0]  mode_now;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] led_count;
        logic [1:0]       init_mode;
        logic             update_effect_enable;
        logic             update_uses_pattern;
        logic [LEN_W-1:0] init_raw_length;
        logic [LEN_W-1:0] update_raw_length;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CNT_W-1:0]  count;
        logic [2:0]        mode;
        logic [RAW_AW-1:0] pos;
        logic [2:0][7:0]   ch;
        logic [RAW_AW-1:0] addr;
        logic [7:0]        data;
    } t_job;

    // One byte lane of a fixed colour, lane 0 is the low byte
    function automatic logic [7:0] colour_byte(input logic [1:0] idx,
                                               input logic [1:0] lane);
        logic [23:0] rgb;
        begin
            case (idx)
                2'd0:    rgb = COLOUR_0;
                2'd1:    rgb = COLOUR_1;
                2'd2:    rgb = COLOUR_2;
                default: rgb = COLOUR_0;
            endcase
            return rgb[{lane, 3'b000} +: 8];
        end
    endfunction

endpackage

FILE: src/led_effect_frame_engine.sv
// ============================================================================
// led_effect_frame_engine: LED effect engine, pattern fades and raw playback
// Decodes opcodes, queues frame jobs, streams a frame byte per unstalled cycle.
// ============================================================================
//
//  Channel   | Handshake                  | Payload
//  ----------+----------------------------+------------------------------
//  input     | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  output    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  config    | psel, penable, pwrite, ... | pwdata / prdata, 32 bits
//
//  A tick in a pattern or raw mode yields led_count transactions (capped at
//  48), one per cycle while the output is not stalled, after the job leaves
//  the queue and passes two pipeline stages (store read, output register).
//  Every other opcode is handled in the front; loads are written to a store
//  by the back. Synchronous active-low reset clears the mode, fade state,
//  raw positions, queue and pipeline; the raw stores are not cleared. The
//  input stalls only while the four-entry job queue is full; output stalls
//  hold the output register and back up through the pipeline into the queue.
//
module led_effect_frame_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lefe_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output lefe_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers
    logic [lefe_pkg::CNT_W-1:0] r_led_count;
    logic [1:0]                 r_init_mode;
    logic                       r_upd_enable;
    logic                       r_upd_pattern;
    logic [lefe_pkg::LEN_W-1:0] r_init_len;
    logic [lefe_pkg::LEN_W-1:0] r_upd_len;

    logic            cfg_write;
    logic [2:0]      reg_idx;
    lefe_pkg::t_cfg  cfg;
    logic            push, queue_full, queue_empty, pop;
    lefe_pkg::t_job  push_job, head_job;

    // Track the expected byte position for the checks below
    logic [lefe_pkg::CNT_W-1:0] r_exp_idx;
    logic                       out_take;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count   <= lefe_pkg::CNT_W'(lefe_pkg::LED_BYTES_MAX);
            r_init_mode   <= '0;
            r_upd_enable  <= 1'b0;
            r_upd_pattern <= 1'b0;
            r_init_len    <= '0;
            r_upd_len     <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                lefe_pkg::REG_LED_COUNT:   r_led_count   <= pwdata[lefe_pkg::CNT_W-1:0];
                lefe_pkg::REG_INIT_MODE:   r_init_mode   <= pwdata[1:0];
                lefe_pkg::REG_UPD_ENABLE:  r_upd_enable  <= pwdata[0];
                lefe_pkg::REG_UPD_PATTERN: r_upd_pattern <= pwdata[0];
                lefe_pkg::REG_INIT_LEN:    r_init_len    <= pwdata[lefe_pkg::LEN_W-1:0];
                lefe_pkg::REG_UPD_LEN:     r_upd_len     <= pwdata[lefe_pkg::LEN_W-1:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Read back the addressed register, zero beyond the list
    always_comb begin
        case (reg_idx)
            lefe_pkg::REG_LED_COUNT:   prdata = 32'(r_led_count);
            lefe_pkg::REG_INIT_MODE:   prdata = 32'(r_init_mode);
            lefe_pkg::REG_UPD_ENABLE:  prdata = 32'(r_upd_enable);
            lefe_pkg::REG_UPD_PATTERN: prdata = 32'(r_upd_pattern);
            lefe_pkg::REG_INIT_LEN:    prdata = 32'(r_init_len);
            lefe_pkg::REG_UPD_LEN:     prdata = 32'(r_upd_len);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.led_count            = r_led_count;
    assign cfg.init_mode            = r_init_mode;
    assign cfg.update_effect_enable = r_upd_enable;
    assign cfg.update_uses_pattern  = r_upd_pattern;
    assign cfg.init_raw_length      = r_init_len;
    assign cfg.update_raw_length    = r_upd_len;

    // Front: decode opcodes, advance effect state, build jobs
    lefe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_cfg        (cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Queue: decouple decode from frame streaming
    lefe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_job   (head_job)
    );

    // Back: apply store loads in order and stream frame bytes
    lefe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    assign out_take = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (out_take) begin
            r_exp_idx <= o_out_item.last_byte ? '0 : o_out_item.byte_index + 1'b1;
        end
    end

    // Frame bytes arrive in order, starting at zero after each last byte
    a_byte_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.byte_index == r_exp_idx)
        else $error("frame byte out of sequence");

    // No frame is ever produced in idle mode
    a_mode_active : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.mode_now != lefe_pkg::MODE_IDLE)
        else $error("frame byte tagged with idle mode");

    // The mode tag holds across one frame
    a_mode_steady : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !o_out_item.last_byte
        |=> !o_out_valid || o_out_item.mode_now == $past(o_out_item.mode_now))
        else $error("mode changed within a frame");

endmodule

FILE: src/lefe_front.sv
// ============================================================================
// lefe_front: opcode decode and frame job builder
// Holds the light mode, fade state and raw positions; emits jobs to the queue.
// ============================================================================
module lefe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lefe_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    input  lefe_pkg::t_cfg      i_cfg,
    input  logic                i_queue_full,
    output logic                o_push,
    output lefe_pkg::t_job      o_job
);

    logic [2:0]                       r_mode, n_mode;
    logic [lefe_pkg::FADE_W-1:0]      r_fade, n_fade;
    logic [1:0]                       r_ci, n_ci;
    logic [lefe_pkg::RAW_AW-1:0]      r_init_pos, n_init_pos;
    logic [lefe_pkg::RAW_AW-1:0]      r_upd_pos, n_upd_pos;

    logic                             accept;
    logic [lefe_pkg::CNT_W-1:0]       frame_len;
    logic [lefe_pkg::FADE_W-1:0]      step;
    logic [1:0]                       ci_src, ci_dst;
    logic [7:0]                       src_b [3];
    logic [7:0]                       dst_b [3];
    logic signed [9:0]                diff [3];
    logic signed [16:0]               prod [3];
    logic signed [16:0]               quo  [3];
    logic [2:0][7:0]                  ch;
    logic [lefe_pkg::LEN_W-1:0]       init_len, upd_len;
    logic [lefe_pkg::LEN_W-1:0]       init_sum, upd_sum;
    logic [lefe_pkg::RAW_AW-1:0]      init_next, upd_next;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // Blend the colour pair at the advanced fade step
    always_comb begin
        frame_len = (i_cfg.led_count > lefe_pkg::CNT_W'(lefe_pkg::LED_BYTES_MAX))
                  ? lefe_pkg::CNT_W'(lefe_pkg::LED_BYTES_MAX) : i_cfg.led_count;
        step = (r_fade == lefe_pkg::FADE_W'(lefe_pkg::FADE_STEPS - 1))
             ? '0 : r_fade + 1'b1;
        if (step == '0) begin
            ci_src = (r_ci == 2'd2) ? 2'd0 : r_ci + 2'd1;
        end else begin
            ci_src = r_ci;
        end
        ci_dst = (ci_src == 2'd2) ? 2'd0 : ci_src + 2'd1;
        for (int c = 0; c < 3; c++) begin
            src_b[c] = lefe_pkg::colour_byte(ci_src, 2'(c));
            dst_b[c] = lefe_pkg::colour_byte(ci_dst, 2'(c));
            diff[c]  = $signed({2'b00, dst_b[c]}) - $signed({2'b00, src_b[c]});
            prod[c]  = diff[c] * $signed({1'b0, step});
            // signed divide by a power of two truncates toward zero
            quo[c]   = 17'(prod[c] / lefe_pkg::FADE_STEPS);
            ch[c]    = src_b[c] + quo[c][7:0];
        end
    end

    // Advance raw positions, wrap to zero at or past the stored length
    always_comb begin
        init_len = (i_cfg.init_raw_length > lefe_pkg::LEN_W'(lefe_pkg::RAW_BYTES_MAX))
                 ? lefe_pkg::LEN_W'(lefe_pkg::RAW_BYTES_MAX) : i_cfg.init_raw_length;
        upd_len  = (i_cfg.update_raw_length > lefe_pkg::LEN_W'(lefe_pkg::RAW_BYTES_MAX))
                 ? lefe_pkg::LEN_W'(lefe_pkg::RAW_BYTES_MAX) : i_cfg.update_raw_length;
        init_sum = lefe_pkg::LEN_W'(r_init_pos) + lefe_pkg::LEN_W'(frame_len);
        upd_sum  = lefe_pkg::LEN_W'(r_upd_pos) + lefe_pkg::LEN_W'(frame_len);
        init_next = (init_sum >= init_len) ? '0 : init_sum[lefe_pkg::RAW_AW-1:0];
        upd_next  = (upd_sum >= upd_len) ? '0 : upd_sum[lefe_pkg::RAW_AW-1:0];
    end

    always_comb begin
        n_mode     = r_mode;
        n_fade     = r_fade;
        n_ci       = r_ci;
        n_init_pos = r_init_pos;
        n_upd_pos  = r_upd_pos;
        o_push     = 1'b0;
        o_job      = '0;
        o_job.count = frame_len;
        o_job.mode  = r_mode;
        o_job.ch    = ch;
        o_job.addr  = i_in_item.store_address[lefe_pkg::RAW_AW-1:0];
        o_job.data  = i_in_item.store_byte;
        if (accept) begin
            case (i_in_item.opcode)
                lefe_pkg::OP_START: begin
                    if (i_cfg.init_mode == lefe_pkg::INIT_SEL_PAT) begin
                        n_mode = lefe_pkg::MODE_INIT_PAT;
                    end else if (i_cfg.init_mode == lefe_pkg::INIT_SEL_RAW) begin
                        n_mode = lefe_pkg::MODE_INIT_RAW;
                    end else begin
                        n_mode = lefe_pkg::MODE_IDLE;
                    end
                end
                lefe_pkg::OP_UPDATE_ON: begin
                    if (!i_cfg.update_effect_enable) begin
                        n_mode = lefe_pkg::MODE_IDLE;
                    end else if (i_cfg.update_uses_pattern) begin
                        n_mode = lefe_pkg::MODE_UPD_PAT;
                    end else begin
                        n_mode = lefe_pkg::MODE_UPD_RAW;
                    end
                end
                lefe_pkg::OP_UPDATE_OFF: begin
                    n_mode = lefe_pkg::MODE_IDLE;
                end
                lefe_pkg::OP_LOAD_INIT: begin
                    o_push     = 1'b1;
                    o_job.kind = lefe_pkg::JOB_LOAD_INIT;
                end
                lefe_pkg::OP_LOAD_UPD: begin
                    o_push     = 1'b1;
                    o_job.kind = lefe_pkg::JOB_LOAD_UPD;
                end
                lefe_pkg::OP_TICK: begin
                    if (frame_len != '0) begin
                        case (r_mode)
                            lefe_pkg::MODE_INIT_PAT, lefe_pkg::MODE_UPD_PAT: begin
                                o_push     = 1'b1;
                                o_job.kind = lefe_pkg::JOB_PAT;
                                n_fade     = step;
                                n_ci       = ci_src;
                            end
                            lefe_pkg::MODE_INIT_RAW: begin
                                o_push     = 1'b1;
                                o_job.kind = lefe_pkg::JOB_INIT_RAW;
                                o_job.pos  = r_init_pos;
                                n_init_pos = init_next;
                            end
                            lefe_pkg::MODE_UPD_RAW: begin
                                o_push     = 1'b1;
                                o_job.kind = lefe_pkg::JOB_UPD_RAW;
                                o_job.pos  = r_upd_pos;
                                n_upd_pos  = upd_next;
                            end
                            default: begin
                                o_push = 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= lefe_pkg::MODE_IDLE;
            r_fade     <= '0;
            r_ci       <= '0;
            r_init_pos <= '0;
            r_upd_pos  <= '0;
        end else begin
            r_mode     <= n_mode;
            r_fade     <= n_fade;
            r_ci       <= n_ci;
            r_init_pos <= n_init_pos;
            r_upd_pos  <= n_upd_pos;
        end
    end

endmodule

FILE: src/lefe_queue.sv
// ============================================================================
// lefe_queue: job queue between front and back
// Small first-in first-out buffer of job records.
// ============================================================================
module lefe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lefe_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lefe_pkg::t_job  o_job
);

    lefe_pkg::t_job                r_slot [lefe_pkg::QUEUE_DEPTH];
    logic [lefe_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [lefe_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [lefe_pkg::QUEUE_AW:0]   r_count, n_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (lefe_pkg::QUEUE_AW + 1)'(lefe_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: src/lefe_back.sv
// ============================================================================
// lefe_back: frame byte sequencer with the two raw frame stores
// Executes store loads and streams frame bytes through a registered output.
// ============================================================================
module lefe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  lefe_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    output lefe_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    logic [7:0] r_init_mem [lefe_pkg::RAW_BYTES_MAX];
    logic [7:0] r_upd_mem  [lefe_pkg::RAW_BYTES_MAX];

    logic                         r_busy, n_busy;
    lefe_pkg::t_job               r_cur;
    logic [lefe_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [1:0]                   r_ph, n_ph;

    logic                         r_s1_valid;
    logic [2:0]                   r_s1_kind;
    logic [lefe_pkg::CNT_W-1:0]   r_s1_idx;
    logic                         r_s1_last;
    logic [2:0]                   r_s1_mode;
    logic [7:0]                   r_s1_pat;
    logic [7:0]                   r_init_rd, r_upd_rd;

    logic                         r_out_valid;
    lefe_pkg::t_out_item          r_out;

    logic                         s1_move, issue, take_frame;
    logic                         wr_init, wr_upd;
    logic [lefe_pkg::RAW_AW-1:0]  rd_addr;
    logic [7:0]                   s1_byte;

    assign o_pop      = r_busy ? 1'b0 : !i_empty;
    assign wr_init    = o_pop && (i_job.kind == lefe_pkg::JOB_LOAD_INIT);
    assign wr_upd     = o_pop && (i_job.kind == lefe_pkg::JOB_LOAD_UPD);
    assign take_frame = o_pop && !wr_init && !wr_upd;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign issue   = r_busy && (!r_s1_valid || s1_move);
    assign rd_addr = r_cur.pos + lefe_pkg::RAW_AW'(r_idx);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_ph   = r_ph;
        if (take_frame) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_ph   = '0;
        end else if (issue) begin
            n_idx = r_idx + 1'b1;
            n_ph  = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
            if (r_idx == r_cur.count - 1'b1) begin
                n_busy = 1'b0;
            end
        end
    end

    // Stores: loads write only while no frame is issuing
    always_ff @(posedge i_clk) begin
        if (wr_init) begin
            r_init_mem[i_job.addr] <= i_job.data;
        end
        if (issue && r_cur.kind == lefe_pkg::JOB_INIT_RAW) begin
            r_init_rd <= r_init_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_upd) begin
            r_upd_mem[i_job.addr] <= i_job.data;
        end
        if (issue && r_cur.kind == lefe_pkg::JOB_UPD_RAW) begin
            r_upd_rd <= r_upd_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_frame) begin
            r_cur <= i_job;
        end
        if (issue) begin
            r_s1_kind <= r_cur.kind;
            r_s1_idx  <= r_idx;
            r_s1_last <= (r_idx == r_cur.count - 1'b1);
            r_s1_mode <= r_cur.mode;
            r_s1_pat  <= r_cur.ch[r_ph];
        end
        if (s1_move) begin
            r_out.frame_byte <= s1_byte;
            r_out.byte_index <= r_s1_idx;
            r_out.last_byte  <= r_s1_last;
            r_out.mode_now   <= r_s1_mode;
        end
    end

    always_comb begin
        case (r_s1_kind)
            lefe_pkg::JOB_INIT_RAW: s1_byte = r_init_rd;
            lefe_pkg::JOB_UPD_RAW:  s1_byte = r_upd_rd;
            default:                s1_byte = r_s1_pat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_ph        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ph   <= n_ph;
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb: testbench of the LED effect frame engine
// Sends opcode transactions and register writes under random idle and stall.
// An in-bench model of the fade and raw playback predicts every frame byte,
// and each output transaction is checked in order against that prediction.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int TOTAL_ITEMS  = 260;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // init_mode values without a package name
    localparam logic [1:0] INIT_SEL_IDLE = 2'd0;
    localparam logic [1:0] INIT_SEL_BAD  = 2'd3;

    // Fade colours side by side, colour 0 in the low 24 bits
    localparam logic [71:0] HUES = {lefe_pkg::COLOUR_2, lefe_pkg::COLOUR_1,
                                    lefe_pkg::COLOUR_0};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    lefe_pkg::t_in_item  i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    lefe_pkg::t_out_item o_out_item;
    logic                i_out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    led_effect_frame_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the registers, at their reset values
    logic [5:0]  led_count_r   = 6'd48;
    logic [1:0]  init_mode_r   = INIT_SEL_IDLE;
    logic        upd_enable_r  = 1'b0;
    logic        upd_pattern_r = 1'b0;
    logic [10:0] init_len_r    = 11'd0;
    logic [10:0] upd_len_r     = 11'd0;

    // Engine state as the bench sees it
    logic [2:0]  light_mode = lefe_pkg::MODE_IDLE;
    logic [5:0]  fade_step  = 6'd0;
    logic [1:0]  hue_idx    = 2'd0;
    int          init_pos   = 0;
    int          upd_pos    = 0;
    logic [7:0]  init_bytes [lefe_pkg::RAW_BYTES_MAX];
    logic [7:0]  upd_bytes  [lefe_pkg::RAW_BYTES_MAX];
    bit          init_known [lefe_pkg::RAW_BYTES_MAX];
    bit          upd_known  [lefe_pkg::RAW_BYTES_MAX];

    // Frame bytes predicted and not yet seen on the output
    lefe_pkg::t_out_item due_bytes [$];

    int          faults      = 0;
    int          idle_cycles = 0;
    int          sent        = 0;      // input transactions accepted so far
    bit          calm        = 1'b0;   // no idle and no stall while set

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    function automatic int pick_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic int frame_len();
        return (led_count_r > lefe_pkg::LED_BYTES_MAX) ? lefe_pkg::LED_BYTES_MAX
                                                        : int'(led_count_r);
    endfunction

    function automatic void flag_mismatch(string msg);
        faults++;
        if (faults <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Advance the bench copy of the engine by one accepted transaction and
    // queue the frame bytes it causes.
    function automatic void advance_engine(lefe_pkg::t_in_item it);
        int                  n;
        int                  len;
        int                  pos;
        int                  cur;
        int                  nxt;
        int                  s;
        int                  d;
        int                  f;
        int                  v;
        int                  k;
        bit                  from_init;
        logic [7:0]          lane  [3];
        logic [7:0]          frame [lefe_pkg::LED_BYTES_MAX];
        lefe_pkg::t_out_item res;

        case (it.opcode)
            lefe_pkg::OP_START: begin
                if (init_mode_r == lefe_pkg::INIT_SEL_PAT)
                    light_mode = lefe_pkg::MODE_INIT_PAT;
                else if (init_mode_r == lefe_pkg::INIT_SEL_RAW)
                    light_mode = lefe_pkg::MODE_INIT_RAW;
                else
                    light_mode = lefe_pkg::MODE_IDLE;
            end
            lefe_pkg::OP_UPDATE_ON: begin
                if (!upd_enable_r)
                    light_mode = lefe_pkg::MODE_IDLE;
                else
                    light_mode = upd_pattern_r ? lefe_pkg::MODE_UPD_PAT
                                               : lefe_pkg::MODE_UPD_RAW;
            end
            lefe_pkg::OP_UPDATE_OFF: light_mode = lefe_pkg::MODE_IDLE;
            lefe_pkg::OP_LOAD_INIT: begin
                init_bytes[it.store_address] = it.store_byte;
                init_known[it.store_address] = 1'b1;
            end
            lefe_pkg::OP_LOAD_UPD: begin
                upd_bytes[it.store_address] = it.store_byte;
                upd_known[it.store_address] = 1'b1;
            end
            lefe_pkg::OP_TICK: begin
                n = frame_len();
                // Idle mode and an empty frame leave everything untouched
                if (light_mode == lefe_pkg::MODE_IDLE || n == 0)
                    return;
                if (light_mode == lefe_pkg::MODE_INIT_PAT ||
                    light_mode == lefe_pkg::MODE_UPD_PAT) begin
                    fade_step = fade_step + 6'd1;
                    if (fade_step == 6'd0)
                        hue_idx = (hue_idx == 2'd2) ? 2'd0 : hue_idx + 2'd1;
                    cur = int'(hue_idx);
                    nxt = (cur + 1) % 3;
                    f   = int'(fade_step);
                    for (k = 0; k < 3; k++) begin
                        s = int'(HUES[cur * 24 + k * 8 +: 8]);
                        d = int'(HUES[nxt * 24 + k * 8 +: 8]);
                        // int division truncates toward zero on a falling channel
                        v = s + ((d - s) * f) / lefe_pkg::FADE_STEPS;
                        lane[k] = v[7:0];
                    end
                    for (k = 0; k < n; k++)
                        frame[k] = lane[k % 3];
                end else begin
                    from_init = (light_mode == lefe_pkg::MODE_INIT_RAW);
                    pos = from_init ? init_pos : upd_pos;
                    len = from_init ? int'(init_len_r) : int'(upd_len_r);
                    if (len > lefe_pkg::RAW_BYTES_MAX)
                        len = lefe_pkg::RAW_BYTES_MAX;
                    // Reads past the top of the store wrap to address zero
                    for (k = 0; k < n; k++)
                        frame[k] = from_init
                                 ? init_bytes[(pos + k) % lefe_pkg::RAW_BYTES_MAX]
                                 : upd_bytes[(pos + k) % lefe_pkg::RAW_BYTES_MAX];
                    pos += n;
                    if (pos >= len)
                        pos = 0;
                    if (from_init)
                        init_pos = pos;
                    else
                        upd_pos = pos;
                end
                for (k = 0; k < n; k++) begin
                    res.frame_byte = frame[k];
                    res.byte_index = k[5:0];
                    res.last_byte  = (k == n - 1);
                    res.mode_now   = light_mode;
                    due_bytes.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one input transaction after a random gap and hold it until taken.
    // Keep valid high across back-to-back transactions.
    task automatic put_item(lefe_pkg::t_in_item it);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        advance_engine(it);
    endtask

    // Load any store byte the coming raw frame would read but that was never
    // written, so playback only ever reads defined bytes.
    task automatic preload_window();
        lefe_pkg::t_in_item it;
        int                 n;
        int                 a;
        int                 k;
        bit                 from_init;
        if (light_mode != lefe_pkg::MODE_INIT_RAW && light_mode != lefe_pkg::MODE_UPD_RAW)
            return;
        n = frame_len();
        from_init = (light_mode == lefe_pkg::MODE_INIT_RAW);
        for (k = 0; k < n; k++) begin
            a = ((from_init ? init_pos : upd_pos) + k) % lefe_pkg::RAW_BYTES_MAX;
            if (from_init ? !init_known[a] : !upd_known[a]) begin
                it.opcode        = from_init ? lefe_pkg::OP_LOAD_INIT : lefe_pkg::OP_LOAD_UPD;
                it.store_address = a[9:0];
                it.store_byte    = 8'($urandom_range(0, 255));
                put_item(it);
            end
        end
    endtask

    task automatic send_op(logic [2:0] code, logic [9:0] addr, logic [7:0] data);
        lefe_pkg::t_in_item it;
        it.opcode        = code;
        it.store_address = addr;
        it.store_byte    = data;
        if (code == lefe_pkg::OP_TICK)
            preload_window();
        put_item(it);
    endtask

    task automatic send_tick();
        send_op(lefe_pkg::OP_TICK, 10'($urandom_range(0, lefe_pkg::RAW_BYTES_MAX - 1)),
                8'($urandom_range(0, 255)));
    endtask

    // Setup phase, access phase, then an idle phase so psel never toggles
    // twice in a step.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            lefe_pkg::REG_LED_COUNT:   led_count_r   = value[5:0];
            lefe_pkg::REG_INIT_MODE:   init_mode_r   = value[1:0];
            lefe_pkg::REG_UPD_ENABLE:  upd_enable_r  = value[0];
            lefe_pkg::REG_UPD_PATTERN: upd_pattern_r = value[0];
            lefe_pkg::REG_INIT_LEN:    init_len_r    = value[10:0];
            lefe_pkg::REG_UPD_LEN:     upd_len_r     = value[10:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait for every predicted byte, then let queued loads and
    // mode changes drain before the registers are touched.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [10:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return 11'd0;
            1:       return 11'd1024;
            2:       return 11'd2047;
            3:       return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(1, 100));
        endcase
    endfunction

    task automatic configure_random();
        int cnt;
        case ($urandom_range(0, 9))
            0:       cnt = 0;
            1:       cnt = 63;
            2:       cnt = 48;
            3, 4:    cnt = $urandom_range(0, 63);
            default: cnt = $urandom_range(1, 8);
        endcase
        cfg_write(lefe_pkg::REG_LED_COUNT, 32'(cnt));
        cfg_write(lefe_pkg::REG_INIT_MODE, 32'($urandom_range(0, 3)));
        cfg_write(lefe_pkg::REG_UPD_ENABLE, 32'($urandom_range(0, 3) != 0));
        cfg_write(lefe_pkg::REG_UPD_PATTERN, 32'($urandom_range(0, 1)));
        cfg_write(lefe_pkg::REG_INIT_LEN, 32'(pick_length()));
        cfg_write(lefe_pkg::REG_UPD_LEN, 32'(pick_length()));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Idle mode: ticks give nothing, spare opcodes are dropped, update on
    // while disabled and a start with an unused init mode both fall to idle.
    task automatic test_idle_ops();
        send_op(lefe_pkg::OP_TICK, 10'h000, 8'h00);
        send_op(OP_SPARE_A, 10'h3FF, 8'hFF);
        send_op(OP_SPARE_B, 10'h2AA, 8'h55);
        send_op(lefe_pkg::OP_UPDATE_ON, 10'h155, 8'hAA);
        send_op(lefe_pkg::OP_TICK, 10'h3FF, 8'hFF);
        send_op(lefe_pkg::OP_START, 10'h000, 8'h00);
        send_op(lefe_pkg::OP_TICK, 10'h000, 8'h00);
        settle();
        cfg_write(lefe_pkg::REG_INIT_MODE, 32'(INIT_SEL_BAD));
        send_op(lefe_pkg::OP_START, 10'h000, 8'h00);
        send_op(lefe_pkg::OP_TICK, 10'h000, 8'h00);
    endtask

    // Init and update pattern frames: saturated, empty, single and short frames.
    task automatic test_pattern_frames();
        settle();
        cfg_write(lefe_pkg::REG_LED_COUNT, 63);
        cfg_write(lefe_pkg::REG_INIT_MODE, 32'(lefe_pkg::INIT_SEL_PAT));
        send_op(lefe_pkg::OP_START, 10'h000, 8'h00);
        send_tick();
        send_tick();
        settle();
        // An empty frame must not advance the fade
        cfg_write(lefe_pkg::REG_LED_COUNT, 0);
        send_tick();
        settle();
        cfg_write(lefe_pkg::REG_LED_COUNT, 1);
        send_tick();
        settle();
        cfg_write(lefe_pkg::REG_LED_COUNT, 5);
        cfg_write(lefe_pkg::REG_UPD_ENABLE, 1);
        cfg_write(lefe_pkg::REG_UPD_PATTERN, 1);
        send_op(lefe_pkg::OP_UPDATE_ON, 10'h000, 8'h00);
        send_tick();
    endtask

    // Raw playback from both stores: wrap on passing the stored length, and
    // a zero length that pins the position at zero.
    task automatic test_raw_playback();
        settle();
        send_op(lefe_pkg::OP_LOAD_INIT, 10'd0, 8'h00);
        send_op(lefe_pkg::OP_LOAD_INIT, 10'd1, 8'hFF);
        send_op(lefe_pkg::OP_LOAD_INIT, 10'd2, 8'hA5);
        send_op(lefe_pkg::OP_LOAD_INIT, 10'd3, 8'h5A);
        send_op(lefe_pkg::OP_LOAD_INIT, 10'd4, 8'h3C);
        send_op(lefe_pkg::OP_LOAD_UPD, 10'h3FF, 8'h81);
        settle();
        cfg_write(lefe_pkg::REG_LED_COUNT, 3);
        cfg_write(lefe_pkg::REG_INIT_MODE, 32'(lefe_pkg::INIT_SEL_RAW));
        cfg_write(lefe_pkg::REG_INIT_LEN, 5);
        send_op(lefe_pkg::OP_START, 10'h000, 8'h00);
        send_tick();
        send_tick();
        send_tick();
        settle();
        cfg_write(lefe_pkg::REG_INIT_LEN, 0);
        send_tick();
        send_tick();
        settle();
        cfg_write(lefe_pkg::REG_UPD_PATTERN, 0);
        cfg_write(lefe_pkg::REG_UPD_LEN, 1);
        send_op(lefe_pkg::OP_UPDATE_ON, 10'h000, 8'h00);
        send_tick();
        send_op(lefe_pkg::OP_UPDATE_OFF, 10'h000, 8'h00);
        send_tick();
    endtask

    // Run the fade past three colour changes so the colour index wraps.
    task automatic test_fade_sweep();
        settle();
        cfg_write(lefe_pkg::REG_LED_COUNT, 4);
        cfg_write(lefe_pkg::REG_UPD_ENABLE, 1);
        cfg_write(lefe_pkg::REG_UPD_PATTERN, 1);
        send_op(lefe_pkg::OP_UPDATE_ON, 10'h000, 8'h00);
        repeat (190) send_tick();
    endtask

    // Phases of random register settings, each opened by a mode change and
    // followed by mostly ticks and loads, with some spare opcodes mixed in.
    task automatic test_random_mix();
        int         span;
        int         pick;
        logic [2:0] code;
        while (sent < TOTAL_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            configure_random();
            span = $urandom_range(15, 45);
            send_op($urandom_range(0, 1) ? lefe_pkg::OP_START : lefe_pkg::OP_UPDATE_ON,
                    10'($urandom_range(0, lefe_pkg::RAW_BYTES_MAX - 1)),
                    8'($urandom_range(0, 255)));
            repeat (span) begin
                if (sent >= TOTAL_ITEMS)
                    break;
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    code = lefe_pkg::OP_TICK;
                else if (pick < 57)
                    code = lefe_pkg::OP_LOAD_INIT;
                else if (pick < 69)
                    code = lefe_pkg::OP_LOAD_UPD;
                else if (pick < 77)
                    code = lefe_pkg::OP_START;
                else if (pick < 85)
                    code = lefe_pkg::OP_UPDATE_ON;
                else if (pick < 92)
                    code = lefe_pkg::OP_UPDATE_OFF;
                else
                    code = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                send_op(code, 10'($urandom_range(0, lefe_pkg::RAW_BYTES_MAX - 1)),
                        8'($urandom_range(0, 255)));
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall per transaction, and the in-order check
    // ------------------------------------------------------------------------

    initial begin : out_stall_driver
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = pick_wait();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_frame_bytes
        lefe_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %h index %0d last %0d mode %0d",
                              o_out_item.frame_byte, o_out_item.byte_index,
                              o_out_item.last_byte, o_out_item.mode_now));
            end else begin
                want = due_bytes.pop_front();
                if (o_out_item.frame_byte !== want.frame_byte ||
                    o_out_item.byte_index !== want.byte_index ||
                    o_out_item.last_byte  !== want.last_byte  ||
                    o_out_item.mode_now   !== want.mode_now) begin
                    flag_mismatch($sformatf(
                        "byte %h/%h index %0d/%0d last %0d/%0d mode %0d/%0d (exp/got)",
                        want.frame_byte, o_out_item.frame_byte,
                        want.byte_index, o_out_item.byte_index,
                        want.last_byte, o_out_item.last_byte,
                        want.mode_now, o_out_item.mode_now));
                end
            end
        end
    end

    // Abort when nothing moves on any port for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL led_effect_frame_engine");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ops();
        test_pattern_frames();
        test_raw_playback();
        test_fade_sweep();
        test_random_mix();
        settle();

        if (faults == 0)
            $display("PASS led_effect_frame_engine");
        else
            $display("FAIL led_effect_frame_engine");
        $finish;
    end

endmodule

FILE: filelist.f
src/lefe_pkg.sv
src/lefe_front.sv
src/lefe_queue.sv
src/lefe_back.sv
src/led_effect_frame_engine.sv
sim/tb.sv
